// ===== rtl/rtxf_pkg.sv =====
`default_nettype none
package rtxf_pkg;

  localparam logic [15:0] LEN_ADD   = 16'd16;
  localparam logic [7:0]  FULL_KEEP = 8'hff;
  localparam int          TYPE_BITS = 8;

  // configuration register indexes
  localparam logic CFG_IDX_PORT = 1'b0;
  localparam logic CFG_IDX_TYPE = 1'b1;

  // request codes on req_type
  localparam logic [1:0] REQ_HDR  = 2'd0;
  localparam logic [1:0] REQ_SEQ  = 2'd1;
  localparam logic [1:0] REQ_BEAT = 2'd2;

  typedef enum logic [2:0] {
    K_TXHDR   = 3'd0,
    K_TXBEAT  = 3'd1,
    K_SEQREQ  = 3'd2,
    K_FINISH  = 3'd3,
    K_BUFBEAT = 3'd4,
    K_ROUTE   = 3'd5
  } kind_t;

  // which sequence of results one accepted item produces
  typedef enum logic [1:0] {
    RUN_SEQREQ = 2'd0,
    RUN_SESS0  = 2'd1,
    RUN_SEQRSP = 2'd2,
    RUN_BEAT   = 2'd3
  } run_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] src_ip;
    logic [31:0] dest_ip;
    logic [15:0] src_udp_port;
    logic [15:0] dst_udp_port;
    logic [15:0] udp_length;
    logic [23:0] seq_number;
    logic [63:0] beat_data;
    logic [7:0]  beat_keep;
    logic        beat_last;
  } item_t;

  typedef struct packed {
    run_t        rtype;
    logic [2:0]  cnt;
    logic [31:0] src_ip;
    logic [31:0] dest_ip;
    logic [15:0] length;
    logic [63:0] data;
    logic [7:0]  keep;
    logic        last;
    logic [7:0]  slot;
  } run_desc_t;

  // replace bits [pos +: width] of word; bits above 63 are dropped
  function automatic logic [63:0] put_field(input logic [63:0] word, input int pos,
                                            input int width, input logic [63:0] val);
    logic [63:0] r;
    r = word;
    for (int b = 0; b < 64; b++) begin
      if (b >= pos && b < pos + width) begin
        r[b] = val[6'(b - pos)];
      end
    end
    return r;
  endfunction

  function automatic kind_t kind_at(input run_t rt, input logic [1:0] step);
    kind_t k;
    k = K_TXBEAT;
    case (rt)
      RUN_SEQREQ: k = K_SEQREQ;
      RUN_SESS0:  k = (step == 2'd0) ? K_TXHDR : K_TXBEAT;
      RUN_SEQRSP: begin
        case (step)
          2'd0:    k = K_TXHDR;
          2'd1:    k = K_ROUTE;
          2'd2:    k = K_TXBEAT;
          default: k = K_BUFBEAT;
        endcase
      end
      RUN_BEAT: begin
        case (step)
          2'd0:    k = K_TXBEAT;
          2'd1:    k = K_BUFBEAT;
          default: k = K_FINISH;
        endcase
      end
      default: k = K_TXBEAT;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rtxf_in_reg.sv =====
`default_nettype none
module rtxf_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rtxf_pkg::item_t item,
  input  wire logic           take,
  output logic                hold_valid,
  output rtxf_pkg::item_t     hold
);
  import rtxf_pkg::*;

  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rtxf_proc.sv =====
`default_nettype none
module rtxf_proc #(
  parameter int SLOT_BITS     = 8,
  parameter int SEQ_BITS      = 24,
  parameter int SRC_SLOT_POS  = 8,
  parameter int DEST_SLOT_POS = 16,
  parameter int TYPE_POS      = 0,
  parameter int SEQ_POS       = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rtxf_pkg::item_t   hold,
  input  wire logic              fire,
  input  wire logic [7:0]        data_type_code,
  output rtxf_pkg::run_desc_t    desc,
  output logic                   desc_valid
);
  import rtxf_pkg::*;

  localparam logic [15:0] SLOT_MASK = 16'((17'd1 << SLOT_BITS) - 17'd1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SEQ     = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] saved_src_ip, saved_src_ip_next;
  logic [31:0] saved_dest_ip, saved_dest_ip_next;
  logic [15:0] saved_length, saved_length_next;
  logic [63:0] word, word_next;
  logic        buffering_on, buffering_on_next;

  logic [63:0] word_hdr;
  logic [63:0] word_s0;
  logic [63:0] word_seq;
  logic [15:0] len_sum;
  logic [15:0] slot_full;

  assign len_sum   = hold.udp_length + LEN_ADD;
  assign slot_full = hold.src_udp_port & SLOT_MASK;

  always_comb begin
    word_hdr = put_field(word, SRC_SLOT_POS, SLOT_BITS, {48'd0, hold.src_udp_port});
    word_hdr = put_field(word_hdr, DEST_SLOT_POS, SLOT_BITS, {48'd0, hold.dst_udp_port});
    word_hdr = put_field(word_hdr, TYPE_POS, TYPE_BITS, {56'd0, data_type_code});
    word_s0  = put_field(word_hdr, SEQ_POS, SEQ_BITS, 64'd0);
    word_seq = put_field(word, SEQ_POS, SEQ_BITS, {40'd0, hold.seq_number});
  end

  always_comb begin
    phase_next         = phase;
    saved_src_ip_next  = saved_src_ip;
    saved_dest_ip_next = saved_dest_ip;
    saved_length_next  = saved_length;
    word_next          = word;
    buffering_on_next  = buffering_on;
    desc_valid         = 1'b0;
    desc               = '0;
    case (phase)
      PH_HEADER: begin
        if (hold.req_type == REQ_HDR) begin
          saved_src_ip_next  = hold.src_ip;
          saved_dest_ip_next = hold.dest_ip;
          saved_length_next  = len_sum;
          desc_valid         = 1'b1;
          if (hold.src_udp_port != 16'd0 && hold.dst_udp_port != 16'd0) begin
            word_next   = word_hdr;
            desc.rtype  = RUN_SEQREQ;
            desc.cnt    = 3'd1;
            desc.slot   = slot_full[7:0];
            phase_next  = PH_SEQ;
          end else begin
            // session 0: header goes out now, payload is not buffered
            word_next         = word_s0;
            desc.rtype        = RUN_SESS0;
            desc.cnt          = 3'd2;
            desc.src_ip       = hold.src_ip;
            desc.dest_ip      = hold.dest_ip;
            desc.length       = len_sum;
            desc.data         = word_s0;
            desc.keep         = FULL_KEEP;
            buffering_on_next = 1'b0;
            phase_next        = PH_PAYLOAD;
          end
        end
      end
      PH_SEQ: begin
        if (hold.req_type == REQ_SEQ) begin
          word_next         = word_seq;
          desc_valid        = 1'b1;
          desc.rtype        = RUN_SEQRSP;
          desc.cnt          = 3'd4;
          desc.src_ip       = saved_src_ip;
          desc.dest_ip      = saved_dest_ip;
          desc.length       = saved_length;
          desc.data         = word_seq;
          desc.keep         = FULL_KEEP;
          buffering_on_next = 1'b1;
          phase_next        = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (hold.req_type == REQ_BEAT) begin
          desc_valid = 1'b1;
          desc.rtype = RUN_BEAT;
          desc.data  = hold.beat_data;
          desc.keep  = hold.beat_keep;
          desc.last  = hold.beat_last;
          if (!buffering_on) begin
            desc.cnt = 3'd1;
          end else if (hold.beat_last) begin
            desc.cnt = 3'd3;
          end else begin
            desc.cnt = 3'd2;
          end
          if (hold.beat_last) begin
            buffering_on_next = 1'b1;
            phase_next        = PH_HEADER;
          end
        end
      end
      default: phase_next = PH_HEADER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      saved_src_ip  <= '0;
      saved_dest_ip <= '0;
      saved_length  <= '0;
      word          <= '0;
      buffering_on  <= 1'b1;
    end else if (fire) begin
      phase         <= phase_next;
      saved_src_ip  <= saved_src_ip_next;
      saved_dest_ip <= saved_dest_ip_next;
      saved_length  <= saved_length_next;
      word          <= word_next;
      buffering_on  <= buffering_on_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rtxf_emit.sv =====
`default_nettype none
module rtxf_emit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire rtxf_pkg::run_desc_t desc,
  input  wire logic [15:0]         fixed_udp_port,
  output logic                     free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_kind,
  output logic [31:0]              hdr_src_ip,
  output logic [31:0]              hdr_dest_ip,
  output logic [15:0]              hdr_src_udp_port,
  output logic [15:0]              hdr_dst_udp_port,
  output logic [15:0]              hdr_length,
  output logic [63:0]              out_data,
  output logic [7:0]               out_keep,
  output logic                     out_beat_last,
  output logic [7:0]               slot_number,
  output logic                     last_of_run
);
  import rtxf_pkg::*;

  logic      active;
  logic [1:0] step;
  run_desc_t run;
  logic      last_step;
  kind_t     kind;

  assign last_step = ({1'b0, step} == run.cnt - 3'd1);
  assign free      = !active || (out_ready && last_step);
  assign out_valid = active;
  assign kind      = kind_at(run.rtype, step);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= 2'd0;
    end else if (load) begin
      active <= 1'b1;
      step   <= 2'd0;
    end else if (active && out_ready) begin
      if (last_step) begin
        active <= 1'b0;
      end else begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run <= desc;
    end
  end

  always_comb begin
    out_kind         = 3'(kind);
    hdr_src_ip       = '0;
    hdr_dest_ip      = '0;
    hdr_src_udp_port = '0;
    hdr_dst_udp_port = '0;
    hdr_length       = '0;
    out_data         = '0;
    out_keep         = '0;
    out_beat_last    = 1'b0;
    slot_number      = '0;
    last_of_run      = last_step;
    case (kind)
      K_TXHDR: begin
        hdr_src_ip       = run.src_ip;
        hdr_dest_ip      = run.dest_ip;
        hdr_src_udp_port = fixed_udp_port;
        hdr_dst_udp_port = fixed_udp_port;
        hdr_length       = run.length;
      end
      K_ROUTE: begin
        hdr_dest_ip = run.dest_ip;
        hdr_length  = run.length;
      end
      K_TXBEAT, K_BUFBEAT: begin
        out_data      = run.data;
        out_keep      = run.keep;
        out_beat_last = run.last;
      end
      K_SEQREQ: slot_number = run.slot;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/reliable_tx_header_framer_unit.sv =====
// An accepted item passes through the input register, then the result register, before
// its first result shows.
// Throughput: one result per cycle while out_ready is high; an item that gives results
// gives 1 to 4 of them, so single-result payload beats stream at one per cycle likewise.
// Reset (rst, synchronous): waits for a user header, buffering on, header word
// and saved header cleared, both configuration registers zero.
`default_nettype none
module reliable_tx_header_framer_unit #(
  parameter int SLOT_BITS     = 8,
  parameter int SEQ_BITS      = 24,
  parameter int SRC_SLOT_POS  = 8,
  parameter int DEST_SLOT_POS = 16,
  parameter int TYPE_POS      = 0,
  parameter int SEQ_POS       = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] src_ip,
  input  wire logic [31:0] dest_ip,
  input  wire logic [15:0] src_udp_port,
  input  wire logic [15:0] dst_udp_port,
  input  wire logic [15:0] udp_length,
  input  wire logic [23:0] seq_number,
  input  wire logic [63:0] beat_data,
  input  wire logic [7:0]  beat_keep,
  input  wire logic        beat_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [31:0]      hdr_src_ip,
  output logic [31:0]      hdr_dest_ip,
  output logic [15:0]      hdr_src_udp_port,
  output logic [15:0]      hdr_dst_udp_port,
  output logic [15:0]      hdr_length,
  output logic [63:0]      out_data,
  output logic [7:0]       out_keep,
  output logic             out_beat_last,
  output logic [7:0]       slot_number,
  output logic             last_of_run
);
  import rtxf_pkg::*;

  logic [15:0] fixed_udp_port;
  logic [7:0]  data_type_code;
  item_t       item;
  item_t       hold;
  logic        hold_valid;
  logic        free;
  logic        fire;
  run_desc_t   desc;
  logic        desc_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_udp_port <= '0;
      data_type_code <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_PORT: fixed_udp_port <= cfg_data;
        CFG_IDX_TYPE: data_type_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.req_type     = req_type;
    item.src_ip       = src_ip;
    item.dest_ip      = dest_ip;
    item.src_udp_port = src_udp_port;
    item.dst_udp_port = dst_udp_port;
    item.udp_length   = udp_length;
    item.seq_number   = seq_number;
    item.beat_data    = beat_data;
    item.beat_keep    = beat_keep;
    item.beat_last    = beat_last;
  end

  // the held item is consumed once the result register can take its run;
  // items of the wrong kind for the phase leave with no results
  assign fire = hold_valid && free;

  rtxf_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item       (item),
    .take       (fire),
    .hold_valid (hold_valid),
    .hold       (hold)
  );

  rtxf_proc #(
    .SLOT_BITS     (SLOT_BITS),
    .SEQ_BITS      (SEQ_BITS),
    .SRC_SLOT_POS  (SRC_SLOT_POS),
    .DEST_SLOT_POS (DEST_SLOT_POS),
    .TYPE_POS      (TYPE_POS),
    .SEQ_POS       (SEQ_POS)
  ) u_proc (
    .clk            (clk),
    .rst            (rst),
    .hold           (hold),
    .fire           (fire),
    .data_type_code (data_type_code),
    .desc           (desc),
    .desc_valid     (desc_valid)
  );

  rtxf_emit u_emit (
    .clk              (clk),
    .rst              (rst),
    .load             (fire && desc_valid),
    .desc             (desc),
    .fixed_udp_port   (fixed_udp_port),
    .free             (free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .hdr_src_ip       (hdr_src_ip),
    .hdr_dest_ip      (hdr_dest_ip),
    .hdr_src_udp_port (hdr_src_udp_port),
    .hdr_dst_udp_port (hdr_dst_udp_port),
    .hdr_length       (hdr_length),
    .out_data         (out_data),
    .out_keep         (out_keep),
    .out_beat_last    (out_beat_last),
    .slot_number      (slot_number),
    .last_of_run      (last_of_run)
  );

endmodule
`default_nettype wire

// ===== rtl/rtxf_checker.sv =====
`default_nettype none
module rtxf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_kind,
  input wire logic [63:0] out_data,
  input wire logic [7:0]  out_keep,
  input wire logic        last_of_run
);
  import rtxf_pkg::*;

  // stalled transfer holds its result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data))
    else $error("output changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == 3'(K_SEQREQ) || out_kind == 3'(K_FINISH)) |-> last_of_run)
    else $error("sequence request or finish not last of its run");

  a_hdr_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == 3'(K_TXHDR) || out_kind == 3'(K_ROUTE)) |-> !last_of_run)
    else $error("header or route info ends a run");

  a_route_then_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_kind == 3'(K_ROUTE)
    |=> out_valid && out_kind == 3'(K_TXBEAT) && out_keep == FULL_KEEP)
    else $error("route info not followed by header word");

endmodule

bind reliable_tx_header_framer_unit rtxf_checker u_rtxf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_kind    (out_kind),
  .out_data    (out_data),
  .out_keep    (out_keep),
  .last_of_run (last_of_run)
);
`default_nettype wire
